### sv/lr_pkg.sv
// Shared definitions for the line rasteriser: default widths, request kinds
// and the line classification flags. No dependencies.
package lr_pkg;

  localparam int LR_COORD_BITS = 11;
  localparam int LR_COLOR_BITS = 24;

  // Request kind carried on in_tuser.
  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } lr_op_t;

  // How a line is drawn, decided once when it starts.
  typedef struct packed {
    logic steep;   // y is the major axis
    logic mirror;  // x falls while y rises
    logic swap;    // endpoints exchanged so that y never decreases
  } lr_class_t;

endpackage

### sv/lr_setup.sv
// Start-of-line setup: classifies the line, orders the endpoints and derives
// the initial error term and both increments. Purely combinational; uses lr_pkg.
module lr_setup #(
  parameter int COORD_BITS = lr_pkg::LR_COORD_BITS
) (
  input  logic [COORD_BITS-1:0]        x_a,
  input  logic [COORD_BITS-1:0]        y_a,
  input  logic [COORD_BITS-1:0]        x_b,
  input  logic [COORD_BITS-1:0]        y_b,
  output lr_pkg::lr_class_t            line_class,
  output logic [COORD_BITS-1:0]        first_x,
  output logic [COORD_BITS-1:0]        first_y,
  output logic [COORD_BITS-1:0]        major_end,
  output logic signed [COORD_BITS+1:0] err_init,
  output logic signed [COORD_BITS+1:0] inc_straight,
  output logic signed [COORD_BITS+1:0] inc_diagonal
);
  import lr_pkg::*;

  localparam int CW = COORD_BITS;

  logic signed [CW:0] dx;
  logic signed [CW:0] dy;
  logic signed [CW:0] dx_neg;
  logic signed [CW:0] dy_neg;
  logic [CW-1:0]      adx;
  logic [CW-1:0]      ady;
  logic [CW-1:0]      amaj;
  logic [CW-1:0]      amin;
  logic [CW:0]        diff;
  logic               dx_lt;
  logic               dy_lt;
  logic               dx_zero;
  logic               dy_zero;
  logic               opposite;

  always_comb begin
    dx      = $signed({1'b0, x_b}) - $signed({1'b0, x_a});
    dy      = $signed({1'b0, y_b}) - $signed({1'b0, y_a});
    dx_neg  = -dx;
    dy_neg  = -dy;
    dx_lt   = dx[CW];
    dy_lt   = dy[CW];
    dx_zero = (dx == '0);
    dy_zero = (dy == '0);
    adx     = dx_lt ? dx_neg[CW-1:0] : dx[CW-1:0];
    ady     = dy_lt ? dy_neg[CW-1:0] : dy[CW-1:0];

    // Both deltas non-zero and of opposite sign.
    opposite = (dx_lt && !dy_lt && !dy_zero) || (!dx_lt && !dx_zero && dy_lt);

    line_class.steep  = (ady > adx);
    line_class.mirror = line_class.steep ? (opposite || (dx_zero && dy_lt)) : opposite;
    line_class.swap   = dy_lt || (dy_zero && dx_lt);

    first_x = line_class.swap ? x_b : x_a;
    first_y = line_class.swap ? y_b : y_a;

    if (line_class.steep) begin
      amaj      = ady;
      amin      = adx;
      major_end = line_class.swap ? y_a : y_b;
    end else begin
      amaj      = adx;
      amin      = ady;
      major_end = line_class.swap ? x_a : x_b;
    end

    diff         = {1'b0, amin} - {1'b0, amaj};
    inc_straight = $signed({1'b0, amin, 1'b0});
    inc_diagonal = $signed({diff, 1'b0});
    err_init     = $signed({1'b0, amin, 1'b0}) - $signed({2'b00, amaj});
  end

endmodule

### sv/line_rasterizer.sv
// Top level of the midpoint line rasteriser: request register, line state,
// pixel stepping and the result register. Depends on lr_pkg and lr_setup.
//
// Usage:
//   Input channel in_*: each request carries its kind on in_tuser. A start
//   request holds both endpoints and a colour in in_tdata and produces the
//   first pixel; an advance request produces the next pixel of the active
//   line and produces nothing when no line is active.
//   Result channel out_*: one pixel per producing request, with out_tlast
//   high on the final pixel of the line. A lone point gives a single pixel
//   with out_tlast set. A start request drops any line still in progress.
//   The request register loads at the edge that accepts the request and the
//   result register loads from it when the request is processed, which a
//   stalled result register holds back.
//   Throughput: one request per cycle while the receiver does not stall, set
//   by the single step of the error term between the two registers.
//   When the receiver stalls, the result register holds its pixel and the
//   request register still takes one more request; in_tready falls only when
//   both are full.
//   Reset clears both valid flags and leaves no line active.
module line_rasterizer #(
  parameter int COORD_BITS = lr_pkg::LR_COORD_BITS,
  parameter int COLOR_BITS = lr_pkg::LR_COLOR_BITS,
  localparam int IN_W  = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // x_start, y_start, x_end, y_end, line_color, then zero padding
  input  logic [IN_W-1:0]  in_tdata,
  // op (lr_pkg::lr_op_t)
  input  logic [0:0]       in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // pixel_x, pixel_y, pixel_color, then zero padding
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tlast
);
  import lr_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int KW = COLOR_BITS;
  localparam int EW = COORD_BITS + 2;

  // Request register
  logic          req_valid_r, req_valid_nxt;
  logic          req_op_r;
  logic [CW-1:0] req_xa_r, req_ya_r, req_xb_r, req_yb_r;
  logic [KW-1:0] req_color_r;

  // Line state
  logic [CW-1:0]        cur_x_r, cur_x_nxt;
  logic [CW-1:0]        cur_y_r, cur_y_nxt;
  logic signed [EW-1:0] err_r, err_nxt;
  logic [CW-1:0]        major_end_r, major_end_nxt;
  logic signed [EW-1:0] inc_str_r, inc_str_nxt;
  logic signed [EW-1:0] inc_diag_r, inc_diag_nxt;
  logic                 steep_r, steep_nxt;
  logic                 mirror_r, mirror_nxt;
  logic                 active_r, active_nxt;
  logic [KW-1:0]        color_r, color_nxt;

  // Result register
  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] out_x_r;
  logic [CW-1:0] out_y_r;
  logic [KW-1:0] out_color_r;
  logic          out_last_r;

  lr_class_t            su_class;
  logic [CW-1:0]        su_x, su_y, su_end;
  logic signed [EW-1:0] su_err, su_inc_str, su_inc_diag;

  logic          proc;
  logic          emit;
  logic          minor;
  logic          fin;
  logic [CW-1:0] major;

  lr_setup #(
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .x_a          (req_xa_r),
    .y_a          (req_ya_r),
    .x_b          (req_xb_r),
    .y_b          (req_yb_r),
    .line_class   (su_class),
    .first_x      (su_x),
    .first_y      (su_y),
    .major_end    (su_end),
    .err_init     (su_err),
    .inc_straight (su_inc_str),
    .inc_diagonal (su_inc_diag)
  );

  assign proc      = req_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !req_valid_r || proc;

  always_comb begin
    req_valid_nxt = req_valid_r;
    if (in_tvalid && in_tready) begin
      req_valid_nxt = 1'b1;
    end else if (proc) begin
      req_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
    end
    if (in_tvalid && in_tready) begin
      req_op_r    <= in_tuser[0];
      req_xa_r    <= in_tdata[CW-1:0];
      req_ya_r    <= in_tdata[2*CW-1:CW];
      req_xb_r    <= in_tdata[3*CW-1:2*CW];
      req_yb_r    <= in_tdata[4*CW-1:3*CW];
      req_color_r <= in_tdata[4*CW+KW-1:4*CW];
    end
  end

  // Line stepping and pixel emission.
  always_comb begin
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    err_nxt       = err_r;
    major_end_nxt = major_end_r;
    inc_str_nxt   = inc_str_r;
    inc_diag_nxt  = inc_diag_r;
    steep_nxt     = steep_r;
    mirror_nxt    = mirror_r;
    active_nxt    = active_r;
    color_nxt     = color_r;

    // A tie steps the minor axis only for a shallow mirrored line.
    minor = (!err_r[EW-1] && (err_r != '0)) || ((err_r == '0) && !steep_r && mirror_r);
    emit  = proc && ((req_op_r == OP_START) || active_r);

    if (proc && (req_op_r == OP_START)) begin
      cur_x_nxt     = su_x;
      cur_y_nxt     = su_y;
      err_nxt       = su_err;
      major_end_nxt = su_end;
      inc_str_nxt   = su_inc_str;
      inc_diag_nxt  = su_inc_diag;
      steep_nxt     = su_class.steep;
      mirror_nxt    = su_class.mirror;
      color_nxt     = req_color_r;
      active_nxt    = 1'b1;
    end else if (emit) begin
      err_nxt = minor ? (err_r + inc_diag_r) : (err_r + inc_str_r);
      if (steep_r) begin
        cur_y_nxt = cur_y_r + 1'b1;
        if (minor) begin
          cur_x_nxt = mirror_r ? (cur_x_r - 1'b1) : (cur_x_r + 1'b1);
        end
      end else begin
        cur_x_nxt = mirror_r ? (cur_x_r - 1'b1) : (cur_x_r + 1'b1);
        if (minor) begin
          cur_y_nxt = cur_y_r + 1'b1;
        end
      end
    end

    major = steep_nxt ? cur_y_nxt : cur_x_nxt;
    fin   = (major == major_end_nxt);
    if (emit && fin) begin
      active_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      err_r       <= '0;
      major_end_r <= '0;
      inc_str_r   <= '0;
      inc_diag_r  <= '0;
      steep_r     <= 1'b0;
      mirror_r    <= 1'b0;
      active_r    <= 1'b0;
      color_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      err_r       <= err_nxt;
      major_end_r <= major_end_nxt;
      inc_str_r   <= inc_str_nxt;
      inc_diag_r  <= inc_diag_nxt;
      steep_r     <= steep_nxt;
      mirror_r    <= mirror_nxt;
      active_r    <= active_nxt;
      color_r     <= color_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (emit) begin
      out_x_r     <= cur_x_nxt;
      out_y_r     <= cur_y_nxt;
      out_color_r <= color_nxt;
      out_last_r  <= fin;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    out_tdata                    = '0;
    out_tdata[CW-1:0]            = out_x_r;
    out_tdata[2*CW-1:CW]         = out_y_r;
    out_tdata[2*CW+KW-1:2*CW]    = out_color_r;
  end

  // An advance with no line in progress must not produce a pixel.
  a_idle_advance_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && (req_op_r == OP_ADVANCE) && !active_r)
      |=> (out_valid_r == $past(out_valid_r && !out_tready)))
    else $error("advance without an active line produced a pixel");

  // A steep line climbs towards its end and never passes it.
  a_steep_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && steep_r) |-> (cur_y_r <= major_end_r))
    else $error("steep line stepped past its end");

  // The last flag of an emitted pixel matches the line ending.
  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (out_last_r == !active_r))
    else $error("last flag disagrees with line state");

endmodule

### dv/tb_top.sv
// Self-checking testbench for line_rasterizer: directed and random line requests
// against an in-bench midpoint line predictor, with random stalls on both sides.
// Depends on lr_pkg and the line_rasterizer RTL.
module tb_top;
  import lr_pkg::*;

  localparam int CB    = LR_COORD_BITS;
  localparam int KB    = LR_COLOR_BITS;
  localparam int IN_W  = ((4 * CB + KB + 7) / 8) * 8;
  localparam int OUT_W = ((2 * CB + KB + 7) / 8) * 8;
  localparam int CMAX  = (1 << CB) - 1;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [CB-1:0] px;
    logic [CB-1:0] py;
    logic [KB-1:0] pc;
    logic          lst;
  } pixel_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic [0:0]       in_tuser = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;

  line_rasterizer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state, mirroring what the stepper keeps between requests.
  logic [CB-1:0]     ln_x, ln_y, ln_major_end;
  logic signed [15:0] ln_err, ln_inc_str, ln_inc_diag;
  logic              ln_steep, ln_mirror, ln_active;
  logic [KB-1:0]     ln_color;

  pixel_t pixel_q[$];
  pixel_t want_pix;
  int n_fail = 0, n_pixels = 0, n_lines_done = 0;
  int n_starts = 0, n_advances = 0, n_counted = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  int rx_hold = 0;

  function automatic void emit_expected_pixel();
    pixel_t p;
    logic [CB-1:0] major;
    major = ln_steep ? ln_y : ln_x;
    p.px  = ln_x;
    p.py  = ln_y;
    p.pc  = ln_color;
    p.lst = (major == ln_major_end);
    if (p.lst) ln_active = 1'b0;
    pixel_q.push_back(p);
  endfunction

  // Returns 1 when the request produces a pixel.
  function automatic bit predict_line_step(lr_op_t op, logic [CB-1:0] xs, logic [CB-1:0] ys,
                                           logic [CB-1:0] xe, logic [CB-1:0] ye,
                                           logic [KB-1:0] color);
    int xa, ya, xb, yb, dx, dy, adx, ady, amaj, amin, t;
    bit opposite, minor;
    if (op == OP_START) begin
      xa = int'(xs); ya = int'(ys); xb = int'(xe); yb = int'(ye);
      dx = xb - xa;
      dy = yb - ya;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      opposite = (dx < 0 && dy > 0) || (dx > 0 && dy < 0);
      ln_steep = ady > adx;
      ln_mirror = ln_steep ? (opposite || (dx == 0 && dy < 0)) : opposite;
      if (dy < 0 || (dy == 0 && dx < 0)) begin
        t = xa; xa = xb; xb = t;
        t = ya; ya = yb; yb = t;
      end
      ln_x = xa[CB-1:0];
      ln_y = ya[CB-1:0];
      ln_color = color;
      if (ln_steep) begin
        amaj = ady; amin = adx; ln_major_end = yb[CB-1:0];
      end else begin
        amaj = adx; amin = ady; ln_major_end = xb[CB-1:0];
      end
      ln_err      = 16'(2 * amin - amaj);
      ln_inc_str  = 16'(2 * amin);
      ln_inc_diag = 16'(2 * (amin - amaj));
      ln_active = 1'b1;
      emit_expected_pixel();
      return 1'b1;
    end
    if (!ln_active) return 1'b0;
    // A tie on a shallow mirrored line takes the minor step.
    minor = (ln_err > 0) || (ln_err == 0 && !ln_steep && ln_mirror);
    ln_err = minor ? ln_err + ln_inc_diag : ln_err + ln_inc_str;
    if (ln_steep) begin
      ln_y = ln_y + 1'b1;
      if (minor) ln_x = ln_mirror ? ln_x - 1'b1 : ln_x + 1'b1;
    end else begin
      ln_x = ln_mirror ? ln_x - 1'b1 : ln_x + 1'b1;
      if (minor) ln_y = ln_y + 1'b1;
    end
    emit_expected_pixel();
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  task automatic send_request(lr_op_t op, logic [CB-1:0] xs, logic [CB-1:0] ys,
                              logic [CB-1:0] xe, logic [CB-1:0] ye, logic [KB-1:0] color);
    int gap;
    bit produced;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_W - 4 * CB - KB){1'b0}}, color, ye, xe, ys, xs};
    do @(posedge clk); while (!in_tready);
    produced = predict_line_step(op, xs, ys, xe, ye, color);
    if (op == OP_START) n_starts++;
    else n_advances++;
    if (produced) n_counted++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic advance(int n);
    repeat (n) send_request(OP_ADVANCE, CB'($urandom), CB'($urandom), CB'($urandom),
                            CB'($urandom), KB'($urandom));
  endtask

  task automatic start_line(int xs, int ys, int xe, int ye, logic [KB-1:0] color);
    send_request(OP_START, CB'(xs), CB'(ys), CB'(xe), CB'(ye), color);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_advance_without_line();
    advance(1);
  endtask

  task automatic test_lone_point();
    start_line(CMAX, CMAX, CMAX, CMAX, {KB{1'b1}});
    advance(1);
  endtask

  task automatic test_special_lines();
    start_line(5, 9, 5, 6, 24'h00ff00);   // vertical, drawn upwards after the swap
    advance(3);
    start_line(0, 0, 3, 3, 24'h123456);   // slope of plus one stays shallow
    advance(3);
    start_line(10, 0, 6, 2, 24'habcdef);  // shallow mirrored with a tie
    advance(4);
    start_line(9, 4, 6, 4, 24'h800001);   // horizontal, right to left
    advance(3);
  endtask

  task automatic test_restart_extremes();
    start_line(0, CMAX, CMAX, 0, 24'h5a5a5a);
    advance(1);
    start_line(CMAX, 0, 0, CMAX, 24'ha5a5a5);  // drops the previous line
    advance(1);
    start_line(0, 0, 0, 0, '0);
  endtask

  task automatic pick_endpoint(input int base, output int other);
    int span, r, d;
    r = $urandom_range(0, 99);
    span = (r < 80) ? 8 : (r < 97) ? 64 : 400;
    d = $urandom_range(0, 2 * span) - span;
    other = base + d;
    if (other < 0 || other > CMAX) other = base - d;
  endtask

  task automatic test_random_lines(int target);
    int xs, ys, xe, ye, len, r, next_drain;
    next_drain = n_counted + 100;
    while (n_counted < target) begin
      quiet = ($urandom_range(0, 99) < 20);
      r = $urandom_range(0, 99);
      if (r < 5) advance($urandom_range(1, 2));
      xs = $urandom_range(0, CMAX);
      ys = $urandom_range(0, CMAX);
      pick_endpoint(xs, xe);
      pick_endpoint(ys, ye);
      start_line(xs, ys, xe, ye, KB'($urandom));
      len = (xe > xs ? xe - xs : xs - xe);
      if ((ye > ys ? ye - ys : ys - ye) > len) len = (ye > ys ? ye - ys : ys - ye);
      r = $urandom_range(0, 99);
      if (r < 10) len = $urandom_range(0, len);
      else if (r < 20) len = len + $urandom_range(1, 3);
      advance(len);
      if (n_counted >= next_drain) begin
        wait_for_drain();
        next_drain = n_counted + $urandom_range(80, 200);
      end
    end
    quiet = 1'b0;
  endtask

  task automatic test_drain_pause();
    start_line(100, 200, 110, 195, 24'h0f0f0f);
    advance(4);
    wait_for_drain();
    advance(6);
  endtask

  // The receiver holds out_tready low for random stretches.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 99) < 25) rx_hold = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pixel_q.size() == 0) begin
        $error("pixel with no request behind it: x=%0d y=%0d", out_tdata[CB-1:0],
               out_tdata[2*CB-1:CB]);
        n_fail++;
      end else begin
        want_pix = pixel_q.pop_front();
        n_pixels++;
        if (want_pix.lst) n_lines_done++;
        if (out_tdata[CB-1:0] !== want_pix.px) begin
          $error("pixel_x: expected %0d, got %0d", want_pix.px, out_tdata[CB-1:0]);
          n_fail++;
        end
        if (out_tdata[2*CB-1:CB] !== want_pix.py) begin
          $error("pixel_y: expected %0d, got %0d", want_pix.py, out_tdata[2*CB-1:CB]);
          n_fail++;
        end
        if (out_tdata[2*CB+KB-1:2*CB] !== want_pix.pc) begin
          $error("pixel_color: expected %h, got %h", want_pix.pc,
                 out_tdata[2*CB+KB-1:2*CB]);
          n_fail++;
        end
        if (out_tlast !== want_pix.lst) begin
          $error("last: expected %0d, got %0d", want_pix.lst, out_tlast);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    ln_x = '0; ln_y = '0; ln_major_end = '0;
    ln_err = '0; ln_inc_str = '0; ln_inc_diag = '0;
    ln_steep = 1'b0; ln_mirror = 1'b0; ln_active = 1'b0; ln_color = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_advance_without_line();
    test_lone_point();
    test_special_lines();
    test_restart_extremes();
    test_drain_pause();
    test_random_lines(n_counted + 1000);
    wait_for_drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d line starts and %0d advance requests; %0d pixels checked.",
             n_starts, n_advances, n_pixels);
    $display("%0d lines were followed to their final pixel.", n_lines_done);
    if (n_fail == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
